[rtl/core/kuf_pkg.sv]
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared types and constants of the Kruskal union-find edge filter.
// ----------------------------------------------------------------------------
package kuf_pkg;

    localparam int VERTEX_W         = 8;
    localparam int VERTEX_SPAN      = 1 << VERTEX_W;
    localparam int VERTEX_COUNT_DEF = 256;
    localparam int RANK_W           = 4;
    localparam int COUNT_W          = 8;

    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    localparam logic KIND_CLEAR = 1'b0;
    localparam logic KIND_EDGE  = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } kuf_in_t;

    typedef struct packed {
        logic                accepted;
        logic [VERTEX_W-1:0] edge_from;
        logic [VERTEX_W-1:0] edge_to;
        logic [COUNT_W-1:0]  tree_edges;
    } kuf_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_COMP,
        ST_START_B,
        ST_LINK,
        ST_BUMP,
        ST_RESP
    } kuf_state_t;

endpackage

[rtl/core/kuf_ram.sv]
// ----------------------------------------------------------------------------
// kuf_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kuf_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/kruskal_union_find_edge_filter.sv]
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Disjoint-set forest with union by rank and full path compression that
// accepts or rejects sorted spanning-tree edges one at a time.
// ----------------------------------------------------------------------------
// A clear or out-of-range request gives its result in the cycle after
// acceptance. An edge finds the root and compresses the path of each endpoint
// in turn, then links the two roots, with an extra step on a rank bump.
// Throughput: one request at a time; the single parent/rank memory is read
// once per cycle while the sequencer walks and rewrites each path.
// Reset: the forest is all singletons and the edge count is zero.
module kruskal_union_find_edge_filter #(
    parameter int VERTEX_COUNT = kuf_pkg::VERTEX_COUNT_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  kuf_pkg::kuf_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output kuf_pkg::kuf_out_t m_payload
);

    import kuf_pkg::*;

    localparam int          MEM_DEPTH = (VERTEX_COUNT < VERTEX_SPAN) ? VERTEX_COUNT
                                                                      : VERTEX_SPAN;
    localparam int          AW        = $clog2(MEM_DEPTH);
    localparam int          EW        = AW + RANK_W;
    localparam logic [31:0] VC_LIMIT  = 32'(VERTEX_COUNT);

    kuf_state_t state_reg, state_next;

    kuf_in_t             in_reg, in_next;
    logic                acc_reg, acc_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic                side_reg, side_next;
    logic [AW-1:0]       root_a_reg, root_a_next;
    logic [AW-1:0]       root_b_reg, root_b_next;
    logic [RANK_W-1:0]   rank_a_reg, rank_a_next;
    logic [RANK_W-1:0]   rank_b_reg, rank_b_next;
    logic [MEM_DEPTH-1:0] valid_reg;
    logic                rd_valid_reg;
    logic [AW-1:0]       rd_addr_reg;

    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic [EW-1:0]       ram_wr_data;
    logic                ram_rd_en;
    logic [AW-1:0]       ram_rd_addr;
    logic [EW-1:0]       ram_rd_data;
    logic                clear_valid;

    logic                edge_ok;
    logic [AW-1:0]       a_idx;
    logic [AW-1:0]       b_idx;
    logic [AW-1:0]       start_idx;
    logic [AW-1:0]       ent_parent;
    logic [RANK_W-1:0]   ent_rank;
    logic [AW-1:0]       cur_root;
    logic                ent_is_root;
    logic                comp_last;
    logic                roots_equal;
    logic                a_dominates;
    logic                needs_bump;

    kuf_ram #(
        .WIDTH (EW),
        .DEPTH (MEM_DEPTH)
    ) u_forest_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // An entry never written since the last clear reads as a singleton root.
    assign ent_parent  = rd_valid_reg ? ram_rd_data[AW-1:0] : rd_addr_reg;
    assign ent_rank    = rd_valid_reg ? ram_rd_data[EW-1:AW] : '0;

    assign edge_ok     = (32'(s_payload.vertex_a) < VC_LIMIT) &&
                         (32'(s_payload.vertex_b) < VC_LIMIT);
    assign a_idx       = in_reg.vertex_a[AW-1:0];
    assign b_idx       = in_reg.vertex_b[AW-1:0];
    assign start_idx   = side_reg ? b_idx : a_idx;
    assign cur_root    = side_reg ? root_b_reg : root_a_reg;
    assign ent_is_root = (ent_parent == cur_reg);
    assign comp_last   = (ent_parent == cur_root);
    assign roots_equal = (root_a_reg == root_b_reg);
    assign a_dominates = (rank_a_reg > rank_b_reg);
    assign needs_bump  = (rank_a_reg == rank_b_reg) && (rank_b_reg != RANK_MAX);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_payload.kind == KIND_EDGE && edge_ok) begin
                        state_next = ST_FIND;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_FIND: begin
                if (ent_is_root) begin
                    if (start_idx != cur_reg) begin
                        state_next = ST_COMP;
                    end else begin
                        state_next = side_reg ? ST_LINK : ST_START_B;
                    end
                end
            end
            ST_COMP: begin
                if (comp_last) begin
                    state_next = side_reg ? ST_LINK : ST_START_B;
                end
            end
            ST_START_B: begin
                state_next = ST_FIND;
            end
            ST_LINK: begin
                if (!roots_equal && !a_dominates && needs_bump) begin
                    state_next = ST_BUMP;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_BUMP: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        in_next     = in_reg;
        acc_next    = acc_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        side_next   = side_reg;
        root_a_next = root_a_reg;
        root_b_next = root_b_reg;
        rank_a_next = rank_a_reg;
        rank_b_next = rank_b_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = cur_reg;
        ram_wr_data = {ent_rank, cur_root};
        ram_rd_en   = 1'b0;
        ram_rd_addr = ent_parent;
        clear_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    in_next  = s_payload;
                    acc_next = 1'b0;
                    if (s_payload.kind == KIND_CLEAR) begin
                        clear_valid = 1'b1;
                        count_next  = '0;
                    end else if (edge_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = s_payload.vertex_a[AW-1:0];
                        cur_next    = s_payload.vertex_a[AW-1:0];
                        side_next   = 1'b0;
                    end
                end
            end
            ST_FIND: begin
                if (ent_is_root) begin
                    if (side_reg) begin
                        root_b_next = cur_reg;
                        rank_b_next = ent_rank;
                    end else begin
                        root_a_next = cur_reg;
                        rank_a_next = ent_rank;
                    end
                    // Walk the path a second time to point it at the root.
                    if (start_idx != cur_reg) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = start_idx;
                        cur_next    = start_idx;
                    end
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ent_parent;
                    cur_next    = ent_parent;
                end
            end
            ST_COMP: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cur_reg;
                ram_wr_data = {ent_rank, cur_root};
                if (!comp_last) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ent_parent;
                    cur_next    = ent_parent;
                end
            end
            ST_START_B: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = b_idx;
                cur_next    = b_idx;
                side_next   = 1'b1;
            end
            ST_LINK: begin
                if (!roots_equal) begin
                    acc_next   = 1'b1;
                    count_next = count_reg + 1'b1;
                    ram_wr_en  = 1'b1;
                    if (a_dominates) begin
                        ram_wr_addr = root_b_reg;
                        ram_wr_data = {rank_b_reg, root_a_reg};
                    end else begin
                        ram_wr_addr = root_a_reg;
                        ram_wr_data = {rank_a_reg, root_b_reg};
                    end
                end
            end
            ST_BUMP: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = root_b_reg;
                ram_wr_data = {rank_b_reg + 1'b1, root_b_reg};
            end
            ST_RESP: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign m_payload = '{accepted:   acc_reg,
                         edge_from:  in_reg.vertex_a,
                         edge_to:    in_reg.vertex_b,
                         tree_edges: count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (clear_valid) begin
                valid_reg <= '0;
            end else if (ram_wr_en) begin
                valid_reg[ram_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        acc_reg    <= acc_next;
        cur_reg    <= cur_next;
        side_reg   <= side_next;
        root_a_reg <= root_a_next;
        root_b_reg <= root_b_next;
        rank_a_reg <= rank_a_next;
        rank_b_reg <= rank_b_next;
        if (ram_rd_en) begin
            rd_valid_reg <= valid_reg[ram_rd_addr];
            rd_addr_reg  <= ram_rd_addr;
        end
    end

endmodule

[rtl/core/kuf_checker.sv]
// ----------------------------------------------------------------------------
// kuf_checker
// Port-level assertions for the Kruskal union-find edge filter.
// ----------------------------------------------------------------------------
module kuf_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input kuf_pkg::kuf_in_t  s_payload,
    input logic              m_valid,
    input logic              m_ready,
    input kuf_pkg::kuf_out_t m_payload
);

    import kuf_pkg::*;

    // A result that is waiting is held until it is taken.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // Only one request is in flight, so the block never takes a new one
    // while a result is pending.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while a result is pending");

    // A clear answers in the next cycle with an empty tree.
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.kind == KIND_CLEAR |=>
            m_valid && !m_payload.accepted && m_payload.tree_edges == '0)
        else $error("clear did not report an empty tree");

    // A self loop always closes a cycle.
    a_self_loop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.edge_from == m_payload.edge_to |-> !m_payload.accepted)
        else $error("self loop accepted");

    // An accepted edge leaves at least one edge in the tree.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.accepted |-> m_payload.tree_edges != '0)
        else $error("accepted edge with zero tree count");

endmodule

bind kruskal_union_find_edge_filter kuf_checker u_kuf_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Kruskal union-find edge filter testbench
// Drives clear and edge requests through the valid/ready input channel and
// checks every result against a disjoint-set forest kept alongside the
// block, with union by rank and full path compression. Directed corner
// cases come first. They are followed by random edge sequences over vertex
// windows of several sizes and by complete merges that build trees of
// rank 8. Flow control on both channels changes from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
    import kuf_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int ITEMS_PER_PHASE = 400;

    typedef logic [VERTEX_W-1:0] vertex_t;

    // Mirrors the forest and predicts one verdict per request.
    class forest_scoreboard;
        vertex_t           up_link [VERTEX_SPAN];
        logic [RANK_W-1:0] rank_val [VERTEX_SPAN];
        logic [COUNT_W-1:0] edge_total;
        kuf_out_t          verdict_q [$];
        int                mismatches;
        int                checked;
        int                clears_seen;
        int                joins_seen;
        int                cycles_seen;
        int                top_rank;

        function new();
            mismatches  = 0;
            checked     = 0;
            clears_seen = 0;
            joins_seen  = 0;
            cycles_seen = 0;
            top_rank    = 0;
            clear_forest();
        endfunction

        function void clear_forest();
            for (int v = 0; v < VERTEX_SPAN; v++) begin
                up_link[v]  = vertex_t'(v);
                rank_val[v] = '0;
            end
            edge_total = '0;
        endfunction

        // Returns the root of v and points every vertex on its path at it.
        function vertex_t find_root(vertex_t v);
            vertex_t root;
            vertex_t cur;
            vertex_t nxt;
            int      steps;
            root  = v;
            steps = 0;
            while (steps < VERTEX_SPAN && up_link[root] != root) begin
                root = up_link[root];
                steps++;
            end
            cur   = v;
            steps = 0;
            while (steps < VERTEX_SPAN && cur != root) begin
                nxt          = up_link[cur];
                up_link[cur] = root;
                cur          = nxt;
                steps++;
            end
            return root;
        endfunction

        function void note_request(kuf_in_t req);
            kuf_out_t verdict;
            vertex_t  ra;
            vertex_t  rb;
            verdict.accepted  = 1'b0;
            verdict.edge_from = req.vertex_a;
            verdict.edge_to   = req.vertex_b;
            if (req.kind == KIND_CLEAR) begin
                clear_forest();
                clears_seen++;
            end else if (int'(req.vertex_a) < VERTEX_COUNT_DEF &&
                         int'(req.vertex_b) < VERTEX_COUNT_DEF) begin
                ra = find_root(req.vertex_a);
                rb = find_root(req.vertex_b);
                if (ra != rb) begin
                    if (rank_val[ra] > rank_val[rb]) begin
                        up_link[rb] = ra;
                    end else begin
                        up_link[ra] = rb;
                        if (rank_val[ra] == rank_val[rb] && rank_val[rb] != RANK_MAX) begin
                            rank_val[rb] = rank_val[rb] + 1'b1;
                            if (int'(rank_val[rb]) > top_rank)
                                top_rank = int'(rank_val[rb]);
                        end
                    end
                    edge_total       = edge_total + 1'b1;
                    verdict.accepted = 1'b1;
                    joins_seen++;
                end else begin
                    cycles_seen++;
                end
            end
            verdict.tree_edges = edge_total;
            verdict_q = {verdict_q, verdict};
        endfunction

        function void check_verdict(kuf_out_t got);
            kuf_out_t want;
            checked++;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request outstanding: acc=%0d %0d-%0d n=%0d",
                             $time, got.accepted, got.edge_from, got.edge_to, got.tree_edges);
                return;
            end
            want = verdict_q.pop_front();
            if (got.accepted !== want.accepted || got.edge_from !== want.edge_from ||
                got.edge_to !== want.edge_to || got.tree_edges !== want.tree_edges) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: expected acc=%0d %0d-%0d n=%0d, got acc=%0d %0d-%0d n=%0d",
                             $time, want.accepted, want.edge_from, want.edge_to,
                             want.tree_edges, got.accepted, got.edge_from, got.edge_to,
                             got.tree_edges);
            end
        endfunction
    endclass

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    kuf_in_t  s_payload = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    kuf_out_t m_payload;

    forest_scoreboard ledger = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_items     = 0;
    int quiet_cycles   = 0;

    kruskal_union_find_edge_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            ledger.check_verdict(m_payload);
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic kuf_in_t make_request(logic kind, vertex_t a, vertex_t b);
        kuf_in_t req;
        req.kind     = kind;
        req.vertex_a = a;
        req.vertex_b = b;
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic push_request(input kuf_in_t req);
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge aclk);
        s_valid   = 1'b1;
        s_payload = req;
        do
            @(posedge aclk);
        while (!s_ready);
        ledger.note_request(req);
        sent_items++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (ledger.verdict_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic push_clear();
        push_request(make_request(KIND_CLEAR, vertex_t'($urandom), vertex_t'($urandom)));
    endtask

    // Merges all vertices level by level into one tree of rank 8.
    task automatic build_full_tree();
        vertex_t perm [VERTEX_SPAN];
        vertex_t tmp;
        vertex_t a;
        vertex_t b;
        int      j;
        int      step;
        for (int v = 0; v < VERTEX_SPAN; v++)
            perm[v] = vertex_t'(v);
        for (int v = VERTEX_SPAN - 1; v > 0; v--) begin
            j       = $urandom_range(0, v);
            tmp     = perm[v];
            perm[v] = perm[j];
            perm[j] = tmp;
        end
        push_clear();
        for (int lvl = 0; lvl < VERTEX_W; lvl++) begin
            step = 1 << lvl;
            for (int i = 0; i < VERTEX_SPAN; i += 2 * step) begin
                // Random members of each half reach deep, uncompressed paths.
                a = perm[i + $urandom_range(0, step - 1)];
                b = perm[i + step + $urandom_range(0, step - 1)];
                if ($urandom_range(0, 1))
                    push_request(make_request(KIND_EDGE, a, b));
                else
                    push_request(make_request(KIND_EDGE, b, a));
            end
        end
        for (int k = 0; k < 8; k++)
            push_request(make_request(KIND_EDGE, vertex_t'($urandom), vertex_t'($urandom)));
    endtask

    task automatic random_sequence();
        int      span;
        int      len;
        vertex_t base;
        vertex_t a;
        vertex_t b;
        case ($urandom_range(0, 3))
            0: span = 4;
            1: span = 16;
            2: span = 64;
            default: span = VERTEX_SPAN;
        endcase
        base = vertex_t'($urandom);
        len  = $urandom_range(8, 60);
        // Now and then a sequence carries on from the previous forest.
        if ($urandom_range(0, 5) != 0)
            push_clear();
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 24) == 0) begin
                push_clear();
            end else if ($urandom_range(0, 19) == 0) begin
                push_request(make_request(KIND_EDGE, vertex_t'($urandom), vertex_t'($urandom)));
            end else begin
                a = base + vertex_t'($urandom_range(0, span - 1));
                b = base + vertex_t'($urandom_range(0, span - 1));
                push_request(make_request(KIND_EDGE, a, b));
            end
        end
    endtask

    initial begin
        int phase_start;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        push_request(make_request(KIND_CLEAR, 8'hFF, 8'h00));
        push_request(make_request(KIND_EDGE, 8'h00, 8'hFF));
        push_request(make_request(KIND_EDGE, 8'hFF, 8'h00));
        push_request(make_request(KIND_EDGE, 8'h07, 8'h07));
        push_request(make_request(KIND_EDGE, 8'h00, 8'h00));
        push_request(make_request(KIND_EDGE, 8'hFF, 8'hFF));
        push_request(make_request(KIND_EDGE, 8'd1, 8'd2));
        push_request(make_request(KIND_EDGE, 8'd3, 8'd4));
        push_request(make_request(KIND_EDGE, 8'd1, 8'd3));
        push_request(make_request(KIND_EDGE, 8'd2, 8'd4));
        push_request(make_request(KIND_EDGE, 8'd5, 8'd1));
        push_request(make_request(KIND_EDGE, 8'd1, 8'd6));
        push_request(make_request(KIND_EDGE, 8'd0, 8'd1));
        push_request(make_request(KIND_CLEAR, 8'h00, 8'hFF));
        push_request(make_request(KIND_EDGE, 8'h00, 8'hFF));
        push_request(make_request(KIND_EDGE, 8'hAA, 8'h55));
        push_request(make_request(KIND_EDGE, 8'h55, 8'hAA));
        push_request(make_request(KIND_CLEAR, 8'h55, 8'hAA));
        push_request(make_request(KIND_EDGE, 8'h55, 8'hAA));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            phase_start = sent_items;
            if (phase == 0 || phase == 2)
                build_full_tree();
            while (sent_items - phase_start < ITEMS_PER_PHASE)
                random_sequence();
            // Hold off new requests until every result of this phase is back.
            wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (ledger.verdict_q.size() != 0) begin
            $display("%0d results never arrived", ledger.verdict_q.size());
            ledger.mismatches += ledger.verdict_q.size();
        end
        $display("Sent %0d requests: %0d clears, %0d joins, %0d cycle rejections, top rank %0d.",
                 sent_items, ledger.clears_seen, ledger.joins_seen, ledger.cycles_seen,
                 ledger.top_rank);
        $display("Checked %0d results across four flow-control phases, %0d mismatches.",
                 ledger.checked, ledger.mismatches);
        if (ledger.mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
